// File: hdl/assert_macros.svh
// assertion macros used by the rtl of the box filter (box_blur_3x3_clamped_edges)
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define BB3_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BB3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/bb3_pkg.sv
// shared constants of the 3x3 box filter
// no dependencies
`default_nettype none

package bb3_pkg;

  // width of the field width register
  localparam int unsigned CFG_W = 12;

  // field width after reset
  localparam int unsigned FIELD_WIDTH_RESET = 257;

  // neighbourhood size and the bits needed to hold it
  localparam int unsigned DIVISOR       = 9;
  localparam int unsigned DIVISOR_CLOG2 = 4;

endpackage

`default_nettype wire

// File: hdl/bb3_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none

module bb3_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read before write on a shared address
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/bb3_div9.sv
// divide by nine of the neighbourhood sum, two register stages
// uses bb3_pkg for the divisor
`default_nettype none

module bb3_div9 #(
  parameter int unsigned SUM_W = 20,
  parameter int unsigned Q_W   = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [SUM_W-1:0] sum_i,
  input  wire logic             eof_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic      [Q_W-1:0]   quot_o,
  output logic                  eof_o
);

  // exact reciprocal: floor(n/d) == (n*m) >> (n_bits + ceil(log2 d))
  localparam int unsigned SHIFT   = SUM_W + bb3_pkg::DIVISOR_CLOG2;
  localparam int unsigned RECIP_W = SUM_W + 1;
  localparam int unsigned LO_W    = SUM_W / 2;
  localparam int unsigned HI_W    = SUM_W - LO_W;
  localparam int unsigned LO_P_W  = LO_W + RECIP_W;
  localparam int unsigned HI_P_W  = HI_W + RECIP_W;
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(bb3_pkg::DIVISOR) - 64'd1) / 64'(bb3_pkg::DIVISOR);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  logic              a_v_q;
  logic [LO_P_W-1:0] pp_lo_q, pp_lo_d;
  logic [HI_P_W-1:0] pp_hi_q, pp_hi_d;
  logic              a_eof_q;
  logic              out_v_q;
  logic [Q_W-1:0]    quot_q, quot_d;
  logic              eof_q;
  logic [PROD_W-1:0] prod;
  logic              b_free;
  logic              a_free;

  assign b_free     = !out_v_q || out_ready_i;
  assign a_free     = !a_v_q || b_free;
  assign in_ready_o = a_free;

  // two partial products against the constant
  assign pp_lo_d = LO_P_W'(sum_i[LO_W-1:0]) * LO_P_W'(RECIP);
  assign pp_hi_d = HI_P_W'(sum_i[SUM_W-1:LO_W]) * HI_P_W'(RECIP);

  assign prod   = PROD_W'(pp_lo_q) + (PROD_W'(pp_hi_q) << LO_W);
  assign quot_d = prod[SHIFT +: Q_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (a_free) begin
        a_v_q <= in_valid_i;
      end
      if (b_free) begin
        out_v_q <= a_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_free && in_valid_i) begin
      pp_lo_q <= pp_lo_d;
      pp_hi_q <= pp_hi_d;
      a_eof_q <= eof_i;
    end
    if (b_free && a_v_q) begin
      quot_q <= quot_d;
      eof_q  <= a_eof_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign quot_o      = quot_q;
  assign eof_o       = eof_q;

endmodule

`default_nettype wire

// File: hdl/box_blur_3x3_clamped_edges.sv
// 3x3 box filter with clamped edges over a square raster field; uses bb3_pkg, bb3_ram, bb3_div9
// one beat per cycle on both sides unless stalled, set by the single line buffer ram port pair
// the window stage holds the closing beat, then the divider's product and output registers
// the row's last result leaves with the next row's first beat, the last row with flush beats
// reset: asynchronous active low; counters and window cleared, field width 257
// line buffer contents stay undefined after reset, there is no clearing pass
`default_nettype none
`include "assert_macros.svh"

module box_blur_3x3_clamped_edges #(
  parameter int unsigned MAX_WIDTH   = 2048,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // configuration write channel
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [bb3_pkg::CFG_W-1:0] cfg_field_width_i,
  // sample input
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0]   height_i,
  input  wire logic                     flush_i,
  // result output
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic      [SAMPLE_BITS-1:0]   smoothed_o,
  output logic                          end_of_frame_o
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  // rows run to width+1: two virtual rows below the field
  localparam int unsigned ROW_W = $clog2(MAX_WIDTH + 2);
  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned SUM_W = SB + bb3_pkg::DIVISOR_CLOG2;
  localparam int unsigned RESET_WIDTH =
    (bb3_pkg::FIELD_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : bb3_pkg::FIELD_WIDTH_RESET;
  localparam logic [COL_W-1:0] LAST_RESET = COL_W'(RESET_WIDTH - 1);

  // beat held in the window stage
  typedef struct packed {
    logic [SB-1:0]    sample;
    logic             phantom;   // virtual row below the field, bottom row repeated
    logic             edge_emit; // rightmost result of the row two above
    logic             main_emit; // result centred one column to the left
    logic             restart;   // end of frame, counters go home
    logic             shift;     // window takes a new column
    logic [COL_W-1:0] col;
  } s1_t;

  // ---------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------
  logic             cfg_fire;
  logic [31:0]      cfg_ext;
  logic [31:0]      eff_width;
  logic [COL_W-1:0] last_q, last_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign cfg_ext     = 32'(cfg_field_width_i);

  // zero acts as one, oversize acts as the largest width
  always_comb begin
    if (cfg_ext == 32'd0) begin
      eff_width = 32'd1;
    end else if (cfg_ext > MAX_WIDTH) begin
      eff_width = MAX_WIDTH;
    end else begin
      eff_width = cfg_ext;
    end
    last_d = COL_W'(eff_width - 32'd1);
  end

  // ---------------------------------------------------------------
  // input side: position counters and classification of the beat
  // ---------------------------------------------------------------
  logic             in_fire;
  logic             load_s1;
  logic [COL_W-1:0] in_col_q;
  logic [ROW_W-1:0] in_row_q;
  logic [ROW_W-1:0] last_row;
  logic             in_phantom, in_restart, in_ignore, in_col_zero;
  logic             in_edge, in_shift, in_main;
  logic             s1_v_q;
  logic             s1_fire;
  logic             s1_free;
  s1_t              s1_q;

  assign s1_free    = !s1_v_q || s1_fire;
  // a config beat takes the frame back to its start, so hold samples off that cycle
  assign in_ready_o = s1_free && !cfg_valid_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign last_row    = ROW_W'(last_q);
  assign in_phantom  = in_row_q > last_row;
  assign in_restart  = in_row_q > (last_row + ROW_W'(1));
  // flush inside the frame does nothing
  assign in_ignore   = flush_i && !in_phantom;
  assign in_col_zero = in_col_q == '0;
  assign in_edge     = in_col_zero && (in_row_q >= ROW_W'(2));
  assign in_shift    = !in_restart;
  assign in_main     = in_shift && !in_col_zero && (in_row_q != '0);
  assign load_s1     = in_fire && !in_ignore;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= LAST_RESET;
      in_col_q <= '0;
      in_row_q <= '0;
      s1_v_q   <= 1'b0;
    end else if (cfg_fire) begin
      last_q   <= last_d;
      in_col_q <= '0;
      in_row_q <= '0;
      s1_v_q   <= 1'b0;
    end else begin
      if (load_s1) begin
        if (in_restart) begin
          in_col_q <= '0;
          in_row_q <= '0;
        end else if (in_col_q == last_q) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + ROW_W'(1);
        end else begin
          in_col_q <= in_col_q + COL_W'(1);
        end
      end
      if (s1_free) begin
        s1_v_q <= load_s1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_s1) begin
      s1_q.sample    <= height_i;
      s1_q.phantom   <= in_phantom;
      s1_q.edge_emit <= in_edge;
      s1_q.main_emit <= in_main;
      s1_q.restart   <= in_restart;
      s1_q.shift     <= in_shift;
      s1_q.col       <= in_col_q;
    end
  end

  // ---------------------------------------------------------------
  // line buffers: upper and middle rows side by side in one ram word
  // ---------------------------------------------------------------
  logic             ram_we, ram_re;
  logic [COL_W-1:0] ram_waddr, ram_raddr;
  logic [2*SB-1:0]  ram_wdata, ram_rdata;
  logic             fwd_q;
  logic [SB-1:0]    fwd_top_q, fwd_mid_q;
  logic [SB-1:0]    rd_top, rd_mid, rd_bot;

  assign ram_re    = load_s1 && in_shift;
  assign ram_raddr = in_col_q;
  assign ram_we    = s1_fire && s1_q.shift && !s1_q.phantom;
  assign ram_waddr = s1_q.col;
  assign ram_wdata = {rd_mid, s1_q.sample};

  bb3_ram #(
    .WIDTH (2 * SB),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // a read that meets the write of the same column (width one) takes the new words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (ram_re) begin
      fwd_q <= ram_we && (ram_waddr == ram_raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      fwd_top_q <= rd_mid;
      fwd_mid_q <= s1_q.sample;
    end
  end

  assign rd_top = fwd_q ? fwd_top_q : ram_rdata[2*SB-1:SB];
  assign rd_mid = fwd_q ? fwd_mid_q : ram_rdata[SB-1:0];
  // below the field the bottom row repeats
  assign rd_bot = s1_q.phantom ? rd_mid : s1_q.sample;

  // ---------------------------------------------------------------
  // window stage: three columns of top, middle, bottom
  // ---------------------------------------------------------------
  logic [SB-1:0]      win_q [3][3];
  logic [SB-1:0]      sel [3][3];
  logic [SB-1:0]      top_sel [3];
  logic [SB+1:0]      col_sum [3];
  logic [SUM_W-1:0]   sum;
  logic [COL_W-1:0]   out_col_q;
  logic [ROW_W-1:0]   out_row_q;
  logic               s1_emit;
  logic               s1_eof;
  logic               div_in_ready;

  // both result kinds take left and centre from the two newest window columns (left as centre in column zero);
  // the right column is the new one, or the centre again at the right edge
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sel[0][r] = (out_col_q == '0) ? win_q[2][r] : win_q[1][r];
      sel[1][r] = win_q[2][r];
    end
    sel[2][0] = s1_q.edge_emit ? win_q[2][0] : rd_top;
    sel[2][1] = s1_q.edge_emit ? win_q[2][1] : rd_mid;
    sel[2][2] = s1_q.edge_emit ? win_q[2][2] : rd_bot;
    for (int k = 0; k < 3; k++) begin
      // top row of the field repeats upwards
      top_sel[k] = (out_row_q == '0) ? sel[k][1] : sel[k][0];
      col_sum[k] = (SB+2)'(top_sel[k]) + (SB+2)'(sel[k][1]) + (SB+2)'(sel[k][2]);
    end
    sum = SUM_W'(col_sum[0]) + SUM_W'(col_sum[1]) + SUM_W'(col_sum[2]);
  end

  assign s1_emit = s1_q.edge_emit || s1_q.main_emit;
  assign s1_eof  = (out_row_q == last_row) && (out_col_q == last_q);
  assign s1_fire = s1_v_q && (!s1_emit || div_in_ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          win_q[c][r] <= '0;
        end
      end
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (cfg_fire || (s1_fire && s1_q.restart)) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          win_q[c][r] <= '0;
        end
      end
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (s1_fire) begin
      if (s1_q.shift) begin
        for (int r = 0; r < 3; r++) begin
          win_q[0][r] <= win_q[1][r];
          win_q[1][r] <= win_q[2][r];
        end
        win_q[2][0] <= rd_top;
        win_q[2][1] <= rd_mid;
        win_q[2][2] <= rd_bot;
      end
      if (s1_emit) begin
        if (out_col_q == last_q) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + ROW_W'(1);
        end else begin
          out_col_q <= out_col_q + COL_W'(1);
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // divide by nine and output register
  // ---------------------------------------------------------------
  bb3_div9 #(
    .SUM_W (SUM_W),
    .Q_W   (SB)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_v_q && s1_emit),
    .in_ready_o  (div_in_ready),
    .sum_i       (sum),
    .eof_i       (s1_eof),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .quot_o      (smoothed_o),
    .eof_o       (end_of_frame_o)
  );

  // ---------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------
  // the last point of the field is only reached on the beat that closes the frame
  `BB3_ASSERT_NOW(a_eof_on_restart, s1_v_q && s1_emit && s1_eof, s1_q.restart,
                  "end of frame result outside the closing beat")
  // both column counters stay inside the field
  `BB3_ASSERT_NOW(a_cols_in_field, 1'b1, (in_col_q <= last_q) && (out_col_q <= last_q),
                  "column counter beyond field width")
  // a read colliding with the write of its column must take the forwarded words
  `BB3_ASSERT_NEXT(a_fwd_on_collision, ram_re && ram_we && (ram_waddr == ram_raddr), fwd_q,
                   "line buffer collision without forwarding")

endmodule

`default_nettype wire

// File: tb/testbench.sv
// self-checking testbench for the 3x3 clamped-edge box filter box_blur_3x3_clamped_edges
// depends on bb3_pkg and the filter rtl; predicts every result from its own copy of the filter state
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_W      = 2048;
  localparam int unsigned HBITS      = 16;
  localparam int unsigned CFG_W      = bb3_pkg::CFG_W;
  // cycles allowed for the output register to empty after the last expected beat
  localparam int unsigned DRAIN      = 8;
  localparam int unsigned RAND_ITEMS = 240;

  typedef logic [HBITS-1:0] height_t;
  typedef height_t column_t [3];   // top, middle, bottom

  typedef struct {
    height_t h;
    logic    fl;
  } sample_beat_t;

  typedef struct {
    height_t smoothed;
    logic    eof;
  } blur_result_t;

  // which side idles while a stretch of stimulus runs
  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  // ---------------------------------------------------------------------------
  // signals towards the filter, all known from time zero
  // ---------------------------------------------------------------------------
  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_width = '0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  height_t          height    = '0;
  logic             flush     = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  height_t          smoothed;
  logic             eof;

  always #1 clk = ~clk;

  box_blur_3x3_clamped_edges #(
    .MAX_WIDTH  (MAX_W),
    .SAMPLE_BITS(HBITS)
  ) dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_field_width_i(cfg_width),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .height_i         (height),
    .flush_i          (flush),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .smoothed_o       (smoothed),
    .end_of_frame_o   (eof)
  );

  // ---------------------------------------------------------------------------
  // filter state as the testbench sees it
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] width_reg;
  height_t          upper_mem  [MAX_W];
  height_t          middle_mem [MAX_W];
  column_t          win        [3];   // oldest .. newest column
  int unsigned      in_col, in_row, out_col, out_row;

  sample_beat_t     pending_beats [$];   // waiting to be driven
  blur_result_t     blur_expected [$];   // predicted, not yet seen at the output
  logic             in_hold = 1'b0;      // a beat is on the input channel, not yet taken
  int unsigned      send_idle_pct  = 0;
  int unsigned      recv_stall_pct = 0;
  int unsigned      fail_count     = 0;

  // width 0 behaves as 1, anything above the line buffer depth as the depth
  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  task automatic clear_frame();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
    for (int k = 0; k < 3; k++) begin
      win[k] = '{default: '0};
    end
  endtask

  // one result from three columns; left and top neighbours clamp at the field edge
  task automatic emit_result(input column_t lc, input column_t cc, input column_t rc,
                             input int unsigned w);
    column_t      cols [3];
    int unsigned  sum;
    int unsigned  top;
    blur_result_t r;
    if (out_col == 0) cols[0] = cc;
    else cols[0] = lc;
    cols[1] = cc;
    cols[2] = rc;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      top = (out_row == 0) ? cols[k][1] : cols[k][0];
      sum = sum + top + int'(cols[k][1]) + int'(cols[k][2]);
    end
    r.smoothed = height_t'(sum / bb3_pkg::DIVISOR);
    r.eof      = (out_row == w - 1) && (out_col == w - 1);
    blur_expected.push_back(r);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
  endtask

  // advance the filter state by one accepted input beat
  task automatic predict_beat(input height_t h, input logic fl);
    int unsigned w;
    int unsigned col;
    logic        phantom;
    height_t     top, mid, bot;
    w       = eff_width();
    phantom = (in_row >= w);
    // flush inside the frame does nothing
    if (!phantom && fl) return;
    col = in_col;
    // last result of the row two above, right neighbour clamped
    if (col == 0 && in_row >= 2) emit_result(win[1], win[2], win[2], w);
    if (in_row >= w + 1) begin
      clear_frame();
      return;
    end
    top = upper_mem[col];
    mid = middle_mem[col];
    if (phantom) begin
      // virtual row below the field repeats the bottom row; sample dropped
      bot = mid;
    end else begin
      bot             = h;
      upper_mem[col]  = mid;
      middle_mem[col] = h;
    end
    win[0] = win[1];
    win[1] = win[2];
    win[2] = '{top, mid, bot};
    if (col >= 1 && in_row >= 1) emit_result(win[0], win[1], win[2], w);
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // input driver and output ready, both change on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!in_hold) begin
      if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        height   <= pending_beats[0].h;
        flush    <= pending_beats[0].fl;
        in_hold   = 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // monitor: output beats checked first, then the input beat is predicted
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    blur_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (blur_expected.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result beat: smoothed %0d eof %0b", smoothed, eof);
        end else begin
          want = blur_expected.pop_front();
          if (smoothed !== want.smoothed || eof !== want.eof) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected smoothed %0d eof %0b, got smoothed %0d eof %0b",
                       want.smoothed, want.eof, smoothed, eof);
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_beat(height, flush);
        void'(pending_beats.pop_front());
        in_hold = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic set_idle(input idle_mode_e m);
    case (m)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 88; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 88; end
      default:   begin send_idle_pct = 29; recv_stall_pct = 29; end
    endcase
  endtask

  task automatic queue_beat(input height_t h, input logic fl);
    sample_beat_t b;
    b.h  = h;
    b.fl = fl;
    pending_beats.push_back(b);
  endtask

  // everything driven and every expected beat seen, then let the pipeline settle
  task automatic wait_quiet();
    while (pending_beats.size() != 0 || in_hold || blur_expected.size() != 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // register write on its own channel; restarts the frame
  task automatic write_width(input logic [CFG_W-1:0] v);
    wait_quiet();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_width <= v;
    do @(posedge clk); while (!cfg_ready);
    width_reg = v;
    clear_frame();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly small fields so that whole frames fit the run
  function automatic logic [CFG_W-1:0] pick_width();
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) return '0;
    if (r < 8) return CFG_W'($urandom_range(3, 1));
    if (r < 17) return CFG_W'($urandom_range(6, 4));
    return CFG_W'($urandom_range(9, 7));
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned w, n, style, phase, rand_count;
    logic        trunc, need_cfg;
    height_t     h;

    width_reg = CFG_W'(bb3_pkg::FIELD_WIDTH_RESET);
    for (int i = 0; i < MAX_W; i++) begin
      upper_mem[i]  = '0;
      middle_mem[i] = '0;
    end
    clear_frame();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset width: one row and a few beats, the first results of the top row come out
    set_idle(IDLE_BOTH);
    for (int i = 0; i < bb3_pkg::FIELD_WIDTH_RESET + 8; i++)
      queue_beat(height_t'($urandom), 1'b0);

    // directed: single-point field via width 0, flush heights must be ignored
    set_idle(IDLE_NONE);
    write_width('0);
    queue_beat('1, 1'b0);
    queue_beat('1, 1'b1);
    queue_beat('0, 1'b1);

    // single point again; a sample after the last one acts as a flush
    write_width(CFG_W'(1));
    queue_beat('0, 1'b0);
    queue_beat('1, 1'b0);
    queue_beat('1, 1'b1);

    // 2x2: flushes before the end of the frame are ignored
    write_width(CFG_W'(2));
    queue_beat('1, 1'b1);
    queue_beat('1, 1'b0);
    queue_beat('0, 1'b0);
    queue_beat('1, 1'b1);
    queue_beat('1, 1'b0);
    queue_beat('0, 1'b0);
    for (int i = 0; i < 3; i++) queue_beat('1, 1'b1);

    // 3x3 of full-scale heights: largest neighbourhood sum
    write_width(CFG_W'(3));
    for (int i = 0; i < 9; i++) queue_beat('1, 1'b0);
    for (int i = 0; i < 4; i++) queue_beat('0, 1'b1);

    // all-ones register value clamps to the line buffer depth; partial frame only
    set_idle(IDLE_BOTH);
    write_width('1);
    for (int i = 0; i < 16; i++) queue_beat(height_t'($urandom), 1'b0);
    need_cfg = 1'b1;

    // random frames, mostly complete, some cut short by a register write
    phase      = 0;
    rand_count = 0;
    while (rand_count < RAND_ITEMS) begin
      set_idle(idle_mode_e'(phase % 4));
      if (need_cfg || $urandom_range(1) == 0) write_width(pick_width());
      need_cfg = 1'b0;
      w     = eff_width();
      style = $urandom_range(3);
      n     = w * w;
      trunc = (n > 1) && ($urandom_range(7) == 0);
      if (trunc) n = $urandom_range(n - 1, 1);
      // the last frame is cut to what is left of the item budget
      if (n > RAND_ITEMS - rand_count) begin
        n     = RAND_ITEMS - rand_count;
        trunc = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
        // stray flush inside the frame
        if ($urandom_range(19) == 0) queue_beat(height_t'($urandom), 1'b1);
        if (style == 0) h = ($urandom_range(1) == 1) ? '1 : '0;
        else h = height_t'($urandom);
        queue_beat(h, 1'b0);
        rand_count++;
      end
      if (trunc) begin
        need_cfg = 1'b1;
      end else begin
        // trailer: mostly flushes, some samples that the filter drops
        for (int i = 0; i <= w; i++) begin
          queue_beat(height_t'($urandom), ($urandom_range(3) != 0));
          rand_count++;
        end
      end
      phase++;
    end

    wait_quiet();
    if (fail_count == 0 && blur_expected.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
+incdir+hdl
hdl/bb3_pkg.sv
hdl/bb3_ram.sv
hdl/bb3_div9.sv
hdl/box_blur_3x3_clamped_edges.sv
tb/testbench.sv
